/* hw/rtl/uniform_grid_profile_store_assert.svh */
// Assertion helpers shared by the RTL. The enclosing module provides clock and reset.
`ifndef UNIFORM_GRID_PROFILE_STORE_ASSERT_SVH
`define UNIFORM_GRID_PROFILE_STORE_ASSERT_SVH

`define UGPS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define UGPS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/ugps_pkg.sv */
package ugps_pkg;

   localparam int VAL_W  = 32;
   localparam int STEP_W = 31;
   localparam int RES_W  = 10;
   localparam int IDX_W  = 10;
   localparam int CNT_W  = 15;
   localparam int DVD_W  = 64;
   localparam int DVS_W  = 32;
   localparam int REQ_W  = 80;

   typedef enum logic [2:0] {
      CMD_RESTART, CMD_PLOT, CMD_RATIO, CMD_COUNT,
      CMD_READ_POS, CMD_READ_IDX, CMD_MIN, CMD_MAX
   } cmd_type;

   typedef enum logic [1:0] {
      ERR_OK, ERR_NOT_INIT, ERR_RANGE, ERR_INDEX
   } err_type;

   typedef enum logic [1:0] {
      CSR_GRID_MIN, CSR_GRID_STEP, CSR_RESOLUTION, CSR_UNUSED
   } csr_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_XL, ST_DECIDE, ST_CLEAR, ST_DIV, ST_CNT, ST_RDWAIT,
      ST_INT1, ST_INT2, ST_INT3, ST_DIV2, ST_SCAN, ST_TAIL, ST_DONE, ST_SPARE
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_MUL, OP_XL, OP_ERR, OP_PLOT, OP_SKIP, OP_CLEAR,
      OP_DIV_OFF, OP_DIV_RATIO, OP_RD_IDX, OP_RD_K, OP_COUNT, OP_TAKE,
      OP_INT1, OP_INT2, OP_DIV_INT, OP_INT_END, OP_SCAN_INIT, OP_SCAN, OP_EMIT
   } op_type;

   typedef struct packed {
      op_type  op;
      err_type err;
      logic    idle;
   } ctl_type;

   typedef struct packed {
      cmd_type cmd;
      logic    init;
      logic    a_lt_x0;
      logic    a_gt_xl;
      logic    a_ge_xl;
      logic    b_gt_xl;
      logic    b_zero;
      logic    idx_bad;
      logic    div_done;
      logic    int_edge;
      logic    clr_last;
      logic    scan_last;
   } sts_type;

endpackage

/* hw/rtl/ugps_div.sv */
module ugps_div
   import ugps_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic [DVD_W-1:0] quot,
   output logic [DVS_W-1:0] rem,
   output logic             done
);

   localparam int CW = $clog2(DVD_W);

   logic [DVD_W-1:0] quo_ff;
   logic [DVS_W:0]   rem_ff;
   logic [DVS_W-1:0] dvs_ff;
   logic [CW-1:0]    cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DVS_W:0]   rem_sh;
   logic             fit;

   assign rem_sh = {rem_ff[DVS_W-1:0], quo_ff[DVD_W-1]};
   assign fit    = rem_sh >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(DVD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DVD_W-2:0], fit};
         rem_ff <= fit ? rem_sh - {1'b0, dvs_ff} : rem_sh;
      end
   end

   assign quot = quo_ff;
   assign rem  = rem_ff[DVS_W-1:0];
   assign done = done_ff;

endmodule

/* hw/rtl/ugps_ctrl.sv */
module ugps_ctrl
   import ugps_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    out_free,
   input  sts_type sts,
   output ctl_type ctl
);

   state_type state_ff;
   state_type state_in;
   logic      count_hit;
   logic      pos_bad;
   logic      span_bad;

   assign count_hit = !sts.a_lt_x0 && !sts.a_ge_xl;
   assign pos_bad   = sts.a_lt_x0 || sts.a_gt_xl;
   assign span_bad  = sts.a_lt_x0 || sts.b_gt_xl;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_MUL;
         end
         ST_MUL: state_in = ST_XL;
         ST_XL:  state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (sts.cmd == CMD_RESTART) begin
               state_in = ST_CLEAR;
            end else if (!sts.init) begin
               state_in = ST_DONE;
            end else begin
               case (sts.cmd)
                  CMD_RATIO:    state_in = sts.b_zero ? ST_DONE : ST_DIV;
                  CMD_COUNT:    state_in = count_hit ? ST_DIV : ST_DONE;
                  CMD_READ_POS: state_in = pos_bad ? ST_DONE : ST_DIV;
                  CMD_READ_IDX: state_in = sts.idx_bad ? ST_DONE : ST_RDWAIT;
                  CMD_MIN, CMD_MAX: state_in = span_bad ? ST_DONE : ST_SCAN;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_CLEAR: begin
            if (sts.clr_last) state_in = ST_DONE;
         end
         ST_DIV: begin
            if (sts.div_done) begin
               if (sts.cmd == CMD_RATIO) state_in = ST_DONE;
               else if (sts.cmd == CMD_COUNT) state_in = ST_CNT;
               else if (sts.int_edge) state_in = ST_RDWAIT;
               else state_in = ST_INT1;
            end
         end
         ST_CNT:    state_in = ST_DONE;
         ST_RDWAIT: state_in = ST_DONE;
         ST_INT1:   state_in = ST_INT2;
         ST_INT2:   state_in = ST_INT3;
         ST_INT3:   state_in = ST_DIV2;
         ST_DIV2: begin
            if (sts.div_done) state_in = ST_DONE;
         end
         ST_SCAN: begin
            if (sts.scan_last) state_in = ST_TAIL;
         end
         ST_TAIL: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl.op   = OP_NONE;
      ctl.err  = ERR_OK;
      ctl.idle = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            ctl.idle = 1'b1;
            if (req_valid) ctl.op = OP_LOAD;
         end
         ST_MUL: ctl.op = OP_MUL;
         ST_XL:  ctl.op = OP_XL;
         ST_DECIDE: begin
            if (sts.cmd == CMD_RESTART) begin
               ctl.op = OP_NONE;
            end else if (!sts.init) begin
               ctl.op  = OP_ERR;
               ctl.err = ERR_NOT_INIT;
            end else begin
               case (sts.cmd)
                  CMD_PLOT:  ctl.op = OP_PLOT;
                  CMD_RATIO: ctl.op = sts.b_zero ? OP_SKIP : OP_DIV_RATIO;
                  CMD_COUNT: ctl.op = count_hit ? OP_DIV_OFF : OP_NONE;
                  CMD_READ_POS: begin
                     ctl.op  = pos_bad ? OP_ERR : OP_DIV_OFF;
                     ctl.err = ERR_RANGE;
                  end
                  CMD_READ_IDX: begin
                     ctl.op  = sts.idx_bad ? OP_ERR : OP_RD_IDX;
                     ctl.err = ERR_INDEX;
                  end
                  CMD_MIN, CMD_MAX: begin
                     ctl.op  = span_bad ? OP_ERR : OP_SCAN_INIT;
                     ctl.err = ERR_RANGE;
                  end
                  default: ctl.op = OP_NONE;
               endcase
            end
         end
         ST_CLEAR: ctl.op = OP_CLEAR;
         ST_DIV: begin
            if (sts.div_done) ctl.op = (sts.cmd == CMD_RATIO) ? OP_PLOT : OP_RD_K;
         end
         ST_CNT:    ctl.op = OP_COUNT;
         ST_RDWAIT: ctl.op = OP_TAKE;
         ST_INT1:   ctl.op = OP_INT1;
         ST_INT2:   ctl.op = OP_INT2;
         ST_INT3:   ctl.op = OP_DIV_INT;
         ST_DIV2: begin
            if (sts.div_done) ctl.op = OP_INT_END;
         end
         ST_SCAN: ctl.op = OP_SCAN;
         ST_DONE: begin
            if (out_free) ctl.op = OP_EMIT;
         end
         default: ctl.op = OP_NONE;
      endcase
   end

endmodule

/* hw/rtl/ugps_dp.sv */
module ugps_dp
   import ugps_pkg::*;
#(
   parameter int MAX_POINTS = 1024,
   parameter int PW         = 11
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ctl_type                  ctl,
   output sts_type                  sts,
   input  logic signed [VAL_W-1:0]  grid_min,
   input  logic [STEP_W-1:0]        grid_step,
   input  logic [RES_W-1:0]         resolution,
   input  cmd_type                  req_cmd,
   input  logic signed [VAL_W-1:0]  req_a,
   input  logic signed [VAL_W-1:0]  req_b,
   input  logic [IDX_W-1:0]         req_idx,
   output logic [VAL_W-1:0]         res_value,
   output logic [CNT_W-1:0]         res_cnt,
   output err_type                  res_err,
   output logic [PW-1:0]            res_wp,
   output logic                     res_full
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int XW = PW + 33;

   cmd_type                 cmd_ff;
   logic signed [VAL_W-1:0] a_ff, b_ff;
   logic [IDX_W-1:0]        idx_ff;
   logic [PW+30:0]          prod_ff;
   logic signed [XW-1:0]    xl_ff, x_ff;
   logic [PW-1:0]           wp_ff;
   logic                    init_ff;
   logic [AW-1:0]           clr_ff, k_ff, scan_ff;
   logic [STEP_W-1:0]       r_ff;
   logic signed [VAL_W-1:0] y0_ff, rdata_ff, res_ff;
   logic signed [63:0]      prod2_ff;
   logic                    neg_ff, pv_ff, have_ff;
   logic [CNT_W-1:0]        cnt_ff;
   err_type                 err_ff;
   logic [VAL_W-1:0]        mem [MAX_POINTS];

   logic [RES_W-1:0]        res_eff;
   logic [16:0]             pts_raw;
   logic [PW-1:0]           pts, pm1;
   logic [STEP_W-1:0]       step;
   logic signed [XW-1:0]    x0_x, a_x, b_x;
   logic [32:0]             off;
   logic [VAL_W-1:0]        abs_a, abs_b;
   logic [63:0]             abs_p;
   logic [DVD_W-1:0]        div_dvd, div_quot;
   logic [DVS_W-1:0]        div_dvs, div_rem;
   logic                    div_go, div_done;
   logic [VAL_W-1:0]        sat_q, pv, qs;
   logic [32:0]             sum33;
   logic [VAL_W-1:0]        nv;
   logic                    wp_lt;
   logic signed [32:0]      dy;
   logic                    we, re;
   logic [AW-1:0]           waddr, raddr;
   logic [VAL_W-1:0]        wdata;
   logic                    better;

   assign res_eff = (resolution == '0) ? RES_W'(1) : resolution;
   assign pts_raw = 17'(res_eff) + 17'd1;
   assign pts     = (pts_raw > 17'(MAX_POINTS)) ? PW'(MAX_POINTS) : PW'(pts_raw);
   assign pm1     = pts - 1'b1;
   assign step    = (grid_step == '0) ? STEP_W'(1) : grid_step;
   assign x0_x    = {{(XW-VAL_W){grid_min[VAL_W-1]}}, grid_min};
   assign a_x     = {{(XW-VAL_W){a_ff[VAL_W-1]}}, a_ff};
   assign b_x     = {{(XW-VAL_W){b_ff[VAL_W-1]}}, b_ff};
   assign off     = {a_ff[VAL_W-1], a_ff} - {grid_min[VAL_W-1], grid_min};
   assign abs_a   = a_ff[VAL_W-1] ? VAL_W'(-a_ff) : a_ff;
   assign abs_b   = b_ff[VAL_W-1] ? VAL_W'(-b_ff) : b_ff;
   assign abs_p   = prod2_ff[63] ? 64'(-prod2_ff) : prod2_ff;
   assign wp_lt   = wp_ff < pts;

   assign sts.cmd       = cmd_ff;
   assign sts.init      = init_ff;
   assign sts.a_lt_x0   = a_ff < grid_min;
   assign sts.a_gt_xl   = a_x > xl_ff;
   assign sts.a_ge_xl   = a_x >= xl_ff;
   assign sts.b_gt_xl   = b_x > xl_ff;
   assign sts.b_zero    = b_ff == '0;
   assign sts.idx_bad   = 17'(idx_ff) >= 17'(pts);
   assign sts.div_done  = div_done;
   assign sts.int_edge  = (div_rem == '0) ||
                          (17'(div_quot[AW-1:0]) + 17'd1 >= 17'(pts));
   assign sts.clr_last  = clr_ff == AW'(MAX_POINTS - 1);
   assign sts.scan_last = 17'(scan_ff) == 17'(pm1);

   always_comb begin
      div_go  = 1'b0;
      div_dvd = {31'd0, off};
      div_dvs = {1'b0, step};
      case (ctl.op)
         OP_DIV_OFF: div_go = 1'b1;
         OP_DIV_RATIO: begin
            div_go  = 1'b1;
            div_dvd = {16'd0, abs_a, 16'd0};
            div_dvs = abs_b;
         end
         OP_DIV_INT: begin
            div_go  = 1'b1;
            div_dvd = abs_p;
         end
         default: div_go = 1'b0;
      endcase
   end

   ugps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .quot     (div_quot),
      .rem      (div_rem),
      .done     (div_done)
   );

   always_comb begin
      if (!neg_ff) begin
         sat_q = (div_quot > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_quot[31:0];
      end else begin
         sat_q = (div_quot > 64'h8000_0000) ? 32'h8000_0000 : 32'(-div_quot[31:0]);
      end
      pv    = (cmd_ff == CMD_PLOT) ? a_ff : sat_q;
      qs    = neg_ff ? 32'(-div_quot[31:0]) : div_quot[31:0];
      sum33 = {rdata_ff[VAL_W-1], rdata_ff} + 33'h1_0000;
      nv    = (!rdata_ff[VAL_W-1] && sum33[31]) ? 32'h7FFF_FFFF : sum33[31:0];
      dy    = {rdata_ff[VAL_W-1], rdata_ff} - {y0_ff[VAL_W-1], y0_ff};
      better = (cmd_ff == CMD_MIN) ? (rdata_ff < res_ff) : (rdata_ff > res_ff);
   end

   always_comb begin
      we    = 1'b0;
      waddr = AW'(wp_ff);
      wdata = pv;
      re    = 1'b0;
      raddr = scan_ff;
      case (ctl.op)
         OP_PLOT: we = wp_lt;
         OP_CLEAR: begin
            we    = 1'b1;
            waddr = clr_ff;
            wdata = '0;
         end
         OP_COUNT: begin
            we    = 1'b1;
            waddr = k_ff;
            wdata = nv;
         end
         OP_RD_IDX: begin
            re    = 1'b1;
            raddr = AW'(idx_ff);
         end
         OP_RD_K: begin
            re    = 1'b1;
            raddr = div_quot[AW-1:0];
         end
         OP_INT1: begin
            re    = 1'b1;
            raddr = k_ff + 1'b1;
         end
         OP_SCAN: re = 1'b1;
         default: re = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         init_ff <= 1'b0;
         pv_ff   <= 1'b0;
      end else begin
         pv_ff <= 1'b0;
         case (ctl.op)
            OP_PLOT, OP_SKIP: begin
               if (wp_lt) wp_ff <= wp_ff + 1'b1;
            end
            OP_CLEAR: begin
               if (sts.clr_last) begin
                  wp_ff   <= '0;
                  init_ff <= 1'b1;
               end
            end
            OP_SCAN: pv_ff <= (x_ff >= a_x) && (x_ff <= b_x);
            default: pv_ff <= 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (ctl.op)
         OP_LOAD: begin
            cmd_ff <= req_cmd;
            a_ff   <= req_a;
            b_ff   <= req_b;
            idx_ff <= req_idx;
            res_ff <= '0;
            cnt_ff <= '0;
            err_ff <= ERR_OK;
            clr_ff <= '0;
         end
         OP_MUL:   prod_ff <= pm1 * step;
         OP_XL:    xl_ff <= x0_x + $signed({2'b00, prod_ff});
         OP_ERR:   err_ff <= ctl.err;
         OP_PLOT:  res_ff <= pv;
         OP_CLEAR: clr_ff <= clr_ff + 1'b1;
         OP_DIV_RATIO: neg_ff <= a_ff[VAL_W-1] ^ b_ff[VAL_W-1];
         OP_RD_K: begin
            k_ff <= div_quot[AW-1:0];
            r_ff <= div_rem[STEP_W-1:0];
         end
         OP_COUNT: begin
            res_ff <= nv;
            cnt_ff <= nv[VAL_W-1] ? '0 : nv[30:16];
         end
         OP_TAKE:    res_ff <= rdata_ff;
         OP_INT1:    y0_ff <= rdata_ff;
         OP_INT2:    prod2_ff <= $signed({1'b0, r_ff}) * dy;
         OP_DIV_INT: neg_ff <= prod2_ff[63];
         OP_INT_END: res_ff <= y0_ff + qs;
         OP_SCAN_INIT: begin
            scan_ff <= '0;
            x_ff    <= x0_x;
            have_ff <= 1'b0;
         end
         OP_SCAN: begin
            scan_ff <= scan_ff + 1'b1;
            x_ff    <= x_ff + $signed({{(XW-STEP_W){1'b0}}, step});
         end
         default: cnt_ff <= cnt_ff;
      endcase
      if (pv_ff && (!have_ff || better)) begin
         res_ff  <= rdata_ff;
         have_ff <= 1'b1;
      end
   end

   assign res_value = res_ff;
   assign res_cnt   = cnt_ff;
   assign res_err   = err_ff;
   assign res_wp    = wp_ff;
   assign res_full  = !wp_lt;

endmodule

/* hw/rtl/uniform_grid_profile_store.sv */
// Channel   Direction  Handshake                 Payload
// req       in         req_tvalid / req_tready   tuser cmd, tdata value_a, value_b, point_index
// rsp       out        rsp_tvalid / rsp_tready   tdata result_value .. profile_full
// csr       in         csr_valid / csr_ready     csr_index, csr_data
//
// One command is worked at a time.
// Ratio, count sample and read at position run the 64-step shared divider;
// an interpolating read runs it again unless the position hits a grid point or the last one;
// min and max walk the store, and restart clears all MAX_POINTS entries.
// The store needs restart after reset before any other command is served.
// A finished result waits in the output register while the next command is taken.
`include "uniform_grid_profile_store_assert.svh"

module uniform_grid_profile_store
   import ugps_pkg::*;
#(
   parameter int MAX_POINTS = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [2:0]            req_tuser,  // cmd
   input  logic [REQ_W-1:0]      req_tdata,  // value_a, value_b, point_index
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // result_value, bin_count, error_code, write_position, profile_full
   output logic [((50 + $clog2(MAX_POINTS + 1) + 7) / 8) * 8 - 1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [VAL_W-1:0]      csr_data
);

   localparam int PW    = $clog2(MAX_POINTS + 1);
   localparam int RSP_W = ((50 + PW + 7) / 8) * 8;

   logic signed [VAL_W-1:0] grid_min_ff;
   logic [STEP_W-1:0]       grid_step_ff;
   logic [RES_W-1:0]        resolution_ff;
   ctl_type                 ctl;
   sts_type                 sts;
   logic                    out_free;
   logic [VAL_W-1:0]        dp_value;
   logic [CNT_W-1:0]        dp_cnt;
   err_type                 dp_err;
   logic [PW-1:0]           dp_wp;
   logic                    dp_full;
   logic                    rsp_valid_ff;
   logic [VAL_W-1:0]        rsp_res_ff;
   logic [CNT_W-1:0]        rsp_cnt_ff;
   err_type                 rsp_err_ff;
   logic [PW-1:0]           rsp_wp_ff;
   logic                    rsp_full_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_min_ff   <= '0;
         grid_step_ff  <= STEP_W'(65536);
         resolution_ff <= RES_W'(1);
      end else if (csr_valid) begin
         case (csr_type'(csr_index))
            CSR_GRID_MIN:   grid_min_ff   <= csr_data;
            CSR_GRID_STEP:  grid_step_ff  <= csr_data[STEP_W-1:0];
            CSR_RESOLUTION: resolution_ff <= csr_data[RES_W-1:0];
            default:        grid_min_ff   <= grid_min_ff;
         endcase
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = ctl.idle;

   ugps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .out_free  (out_free),
      .sts       (sts),
      .ctl       (ctl)
   );

   ugps_dp #(
      .MAX_POINTS (MAX_POINTS),
      .PW         (PW)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .sts        (sts),
      .grid_min   (grid_min_ff),
      .grid_step  (grid_step_ff),
      .resolution (resolution_ff),
      .req_cmd    (cmd_type'(req_tuser)),
      .req_a      (req_tdata[31:0]),
      .req_b      (req_tdata[63:32]),
      .req_idx    (req_tdata[73:64]),
      .res_value  (dp_value),
      .res_cnt    (dp_cnt),
      .res_err    (dp_err),
      .res_wp     (dp_wp),
      .res_full   (dp_full)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.op == OP_EMIT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.op == OP_EMIT) begin
         rsp_res_ff  <= dp_value;
         rsp_cnt_ff  <= dp_cnt;
         rsp_err_ff  <= dp_err;
         rsp_wp_ff   <= dp_wp;
         rsp_full_ff <= dp_full;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_full_ff, rsp_wp_ff, rsp_err_ff, rsp_cnt_ff, rsp_res_ff});

   `UGPS_ASSERT_IMP(a_emit_free, ctl.op == OP_EMIT, !rsp_valid_ff || rsp_tready, "result overwritten")
   `UGPS_ASSERT_NXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready, "second command taken")
   `UGPS_ASSERT_IMP(a_err_zero, rsp_valid_ff && rsp_err_ff != ERR_OK, rsp_res_ff == '0 && rsp_cnt_ff == '0, "error reply carries data")
   `UGPS_ASSERT_IMP(a_cnt_ok, rsp_valid_ff && rsp_cnt_ff != '0, rsp_err_ff == ERR_OK && !rsp_res_ff[31], "bad bin count reply")

endmodule
